// ===== design/swsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sleeper wake and steal manager package
// Field widths, operation codes, counter limits and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package swsm_pkg;

   localparam int OP_W       = 3;
   localparam int CI_W       = 4;
   localparam int ACTIVE_W   = 5;
   localparam int COUNT_W    = 5;

   localparam int DEFAULT_MAX_CONSUMERS = 16;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 5'd31;

   localparam logic [OP_W-1:0] OP_NEW_TASK  = 3'd0;
   localparam logic [OP_W-1:0] OP_WAKE      = 3'd1;
   localparam logic [OP_W-1:0] OP_SLEEP     = 3'd2;
   localparam logic [OP_W-1:0] OP_STEAL_REQ = 3'd3;
   localparam logic [OP_W-1:0] OP_STEAL_END = 3'd4;
   localparam logic [OP_W-1:0] OP_STOP      = 3'd5;

   typedef struct packed {
      logic            woken_valid;
      logic [CI_W-1:0] woken_index;
      logic            steal_granted;
      logic            was_last_stealer;
      logic            stopped_flag;
      logic            last_result;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/swsm_queue_ram.sv =====
// ----------------------------------------------------------------------------
// Sleeper queue memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swsm_queue_ram
   import swsm_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_CONSUMERS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [CI_W-1:0]          wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [CI_W-1:0]          rd_data
);

   logic [CI_W-1:0] mem_ff [DEPTH];
   logic [CI_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sleeper_wake_and_steal_manager_core.sv =====
// Most transactions give their result from the output register in the cycle after acceptance.
// A new task that wakes pops queue entries, skipping stale ones, until it finds a sleeper.
// Stop gives one result for each sleeper it wakes, in queue order, and flags the last one.
// Throughput: one transaction per cycle when nothing pops the queue and the result is not held.
// Reset clears all flags, counters and pointers; the queue memory needs no clearing.
// ----------------------------------------------------------------------------
// Sleeper wake and steal manager core
// Tracks sleeping consumers in a memory-backed queue and grants or ends steals.
// ----------------------------------------------------------------------------
`default_nettype none

module sleeper_wake_and_steal_manager_core
   import swsm_pkg::*;
#(
   parameter int MAX_CONSUMERS = DEFAULT_MAX_CONSUMERS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [CI_W-1:0]     req_consumer_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_woken_valid,
   output logic      [CI_W-1:0]     rsp_woken_index,
   output logic                     rsp_steal_granted,
   output logic                     rsp_was_last_stealer,
   output logic                     rsp_stopped_flag,
   output logic                     rsp_last_result,
   input  wire logic                csr_wr_en,
   input  wire logic [ACTIVE_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_CONSUMERS);
   localparam int FCNT_W = $clog2(MAX_CONSUMERS + 1);

   typedef enum logic {ST_IDLE, ST_POP} state_type;

   state_type                state_ff, state_in;
   logic                     stop_mode_ff, stop_mode_in;
   logic [MAX_CONSUMERS-1:0] sleeping_ff, sleeping_in;
   logic [MAX_CONSUMERS-1:0] queued_ff, queued_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [FCNT_W-1:0]        fifo_count_ff, fifo_count_in;
   logic [COUNT_W-1:0]       sleeper_count_ff, sleeper_count_in;
   logic [COUNT_W-1:0]       stealer_count_ff, stealer_count_in;
   logic                     halted_ff, halted_in;
   logic [ACTIVE_W-1:0]      active_ff, active_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [CI_W-1:0]          rd_data;

   logic                     out_free;
   logic                     accept;
   logic                     ci_ok;
   logic [IDX_W-1:0]         ci_idx;
   logic [IDX_W-1:0]         head_next;
   logic [IDX_W-1:0]         tail_next;
   logic [IDX_W-1:0]         pop_idx;
   logic [MAX_CONSUMERS-1:0] others_asleep;

   function automatic rsp_type make_rsp(input logic wv, input logic [CI_W-1:0] wi,
                                        input logic sg, input logic wl,
                                        input logic sf, input logic last);
      rsp_type r;
      r.woken_valid      = wv;
      r.woken_index      = wi;
      r.steal_granted    = sg;
      r.was_last_stealer = wl;
      r.stopped_flag     = sf;
      r.last_result      = last;
      return r;
   endfunction

   swsm_queue_ram #(
      .DEPTH(MAX_CONSUMERS)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_consumer_index),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign ci_ok     = 32'(req_consumer_index) < MAX_CONSUMERS;
   assign ci_idx    = IDX_W'(req_consumer_index);
   assign head_next = (head_ff == IDX_W'(MAX_CONSUMERS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(MAX_CONSUMERS - 1)) ? '0 : tail_ff + 1'b1;
   assign pop_idx   = IDX_W'(rd_data);

   always_comb begin
      others_asleep          = sleeping_ff;
      others_asleep[pop_idx] = 1'b0;
   end

   always_comb begin
      state_in         = state_ff;
      stop_mode_in     = stop_mode_ff;
      sleeping_in      = sleeping_ff;
      queued_in        = queued_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      fifo_count_in    = fifo_count_ff;
      sleeper_count_in = sleeper_count_ff;
      stealer_count_in = stealer_count_ff;
      halted_in        = halted_ff;
      active_in        = csr_wr_en ? csr_wr_data : active_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in           = rsp_ff;
      wr_en            = 1'b0;
      wr_addr          = tail_ff;
      rd_en            = 1'b0;
      rd_addr          = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(1'b0, '0, 1'b0, 1'b0, halted_ff, 1'b1);
               case (req_opcode)
                  OP_NEW_TASK: begin
                     if (sleeper_count_ff != '0 && stealer_count_ff == '0 &&
                         fifo_count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        stop_mode_in = 1'b0;
                        state_in     = ST_POP;
                     end
                  end
                  OP_WAKE: begin
                     if (ci_ok && sleeping_ff[ci_idx]) begin
                        sleeping_in[ci_idx] = 1'b0;
                        if (sleeper_count_ff != '0) begin
                           sleeper_count_in = sleeper_count_ff - 1'b1;
                        end
                     end
                  end
                  OP_SLEEP: begin
                     if (ci_ok && !sleeping_ff[ci_idx]) begin
                        sleeping_in[ci_idx] = 1'b1;
                        if (!queued_ff[ci_idx] &&
                            fifo_count_ff < FCNT_W'(MAX_CONSUMERS)) begin
                           wr_en             = 1'b1;
                           tail_in           = tail_next;
                           fifo_count_in     = fifo_count_ff + 1'b1;
                           queued_in[ci_idx] = 1'b1;
                        end
                        if (sleeper_count_ff < COUNT_MAX) begin
                           sleeper_count_in = sleeper_count_ff + 1'b1;
                        end
                     end
                  end
                  OP_STEAL_REQ: begin
                     if ({stealer_count_ff, 1'b0} < {1'b0, active_ff} &&
                         stealer_count_ff < COUNT_MAX) begin
                        stealer_count_in     = stealer_count_ff + 1'b1;
                        rsp_in.steal_granted = 1'b1;
                     end
                  end
                  OP_STEAL_END: begin
                     rsp_in.was_last_stealer = (stealer_count_ff == COUNT_W'(1));
                     if (stealer_count_ff != '0) begin
                        stealer_count_in = stealer_count_ff - 1'b1;
                     end
                  end
                  OP_STOP: begin
                     halted_in           = 1'b1;
                     rsp_in.stopped_flag = 1'b1;
                     if (sleeping_ff != '0 && fifo_count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        stop_mode_in = 1'b1;
                        state_in     = ST_POP;
                     end else begin
                        head_in       = tail_ff;
                        fifo_count_in = '0;
                        queued_in     = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            if (fifo_count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(1'b0, '0, 1'b0, 1'b0, halted_ff, 1'b1);
                  state_in     = ST_IDLE;
               end
            end else if (sleeping_ff[pop_idx]) begin
               if (out_free) begin
                  head_in              = head_next;
                  fifo_count_in        = fifo_count_ff - 1'b1;
                  queued_in[pop_idx]   = 1'b0;
                  sleeping_in[pop_idx] = 1'b0;
                  if (sleeper_count_ff != '0) begin
                     sleeper_count_in = sleeper_count_ff - 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  if (!stop_mode_ff) begin
                     rsp_in   = make_rsp(1'b1, rd_data, 1'b0, 1'b0, halted_ff, 1'b1);
                     state_in = ST_IDLE;
                  end else if (others_asleep == '0) begin
                     rsp_in        = make_rsp(1'b1, rd_data, 1'b0, 1'b0, halted_ff, 1'b1);
                     head_in       = tail_ff;
                     fifo_count_in = '0;
                     queued_in     = '0;
                     state_in      = ST_IDLE;
                  end else begin
                     rsp_in  = make_rsp(1'b1, rd_data, 1'b0, 1'b0, halted_ff, 1'b0);
                     rd_en   = 1'b1;
                     rd_addr = head_next;
                  end
               end
            end else begin
               head_in            = head_next;
               fifo_count_in      = fifo_count_ff - 1'b1;
               queued_in[pop_idx] = 1'b0;
               rd_en              = 1'b1;
               rd_addr            = head_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         stop_mode_ff     <= 1'b0;
         sleeping_ff      <= '0;
         queued_ff        <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         fifo_count_ff    <= '0;
         sleeper_count_ff <= '0;
         stealer_count_ff <= '0;
         halted_ff        <= 1'b0;
         active_ff        <= ACTIVE_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         stop_mode_ff     <= stop_mode_in;
         sleeping_ff      <= sleeping_in;
         queued_ff        <= queued_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         fifo_count_ff    <= fifo_count_in;
         sleeper_count_ff <= sleeper_count_in;
         stealer_count_ff <= stealer_count_in;
         halted_ff        <= halted_in;
         active_ff        <= active_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_woken_valid      = rsp_ff.woken_valid;
   assign rsp_woken_index      = rsp_ff.woken_index;
   assign rsp_steal_granted    = rsp_ff.steal_granted;
   assign rsp_was_last_stealer = rsp_ff.was_last_stealer;
   assign rsp_stopped_flag     = rsp_ff.stopped_flag;
   assign rsp_last_result      = rsp_ff.last_result;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Sleeper wake and steal manager testbench
// Drives notices, steal traffic and stops through the request channel while a
// cycle-free model of the sleeper queue and counters predicts every result.
// The model's results are checked field by field as they leave the block.
// Both channels see random idle bursts, and the active consumer register is
// swept through its extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swsm_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int NUM_CONSUMERS = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 32;
   localparam int PEND_DEPTH    = 64;

   class wake_steal_ledger;
      logic [ACTIVE_W-1:0] active;
      bit                  asleep[NUM_CONSUMERS];
      bit                  queued[NUM_CONSUMERS];
      logic [CI_W-1:0]     slots[NUM_CONSUMERS];
      logic [CI_W-1:0]     head;
      logic [CI_W-1:0]     tail;
      int                  queue_len;
      int                  sleepers;
      int                  stealers;
      bit                  halted;
      rsp_type             pending[PEND_DEPTH];
      int                  pend_rd;
      int                  pend_wr;
      int                  pend_count;
      int                  mismatches;

      function new();
         active     = ACTIVE_RESET;
         head       = '0;
         tail       = '0;
         queue_len  = 0;
         sleepers   = 0;
         stealers   = 0;
         halted     = 1'b0;
         pend_rd    = 0;
         pend_wr    = 0;
         pend_count = 0;
         mismatches = 0;
         foreach (asleep[i]) begin
            asleep[i] = 1'b0;
            queued[i] = 1'b0;
            slots[i]  = '0;
         end
      endfunction

      function void add_expected(rsp_type r);
         pending[pend_wr] = r;
         pend_wr          = (pend_wr + 1) % PEND_DEPTH;
         pend_count       = pend_count + 1;
      endfunction

      function rsp_type take_expected();
         rsp_type r;
         r          = pending[pend_rd];
         pend_rd    = (pend_rd + 1) % PEND_DEPTH;
         pend_count = pend_count - 1;
         return r;
      endfunction

      function logic [CI_W-1:0] pop_oldest();
         logic [CI_W-1:0] c;
         c         = slots[head];
         head      = head + 1'b1;
         queue_len = queue_len - 1;
         queued[c] = 1'b0;
         return c;
      endfunction

      function bit wake_oldest(output logic [CI_W-1:0] c);
         logic [CI_W-1:0] cand;
         c = '0;
         while (queue_len > 0) begin
            cand = pop_oldest();
            if (asleep[cand]) begin
               asleep[cand] = 1'b0;
               if (sleepers > 0) sleepers = sleepers - 1;
               c = cand;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CI_W-1:0] ci);
         rsp_type         r;
         logic [CI_W-1:0] c;
         logic [CI_W-1:0] woken[NUM_CONSUMERS];
         int              n_woken;
         n_woken       = 0;
         r             = '0;
         r.last_result = 1'b1;
         case (op)
            OP_NEW_TASK: begin
               if (sleepers > 0 && stealers == 0 && wake_oldest(c)) begin
                  r.woken_valid = 1'b1;
                  r.woken_index = c;
               end
            end
            OP_WAKE: begin
               if (asleep[ci]) begin
                  asleep[ci] = 1'b0;
                  if (sleepers > 0) sleepers = sleepers - 1;
               end
            end
            OP_SLEEP: begin
               if (!asleep[ci]) begin
                  asleep[ci] = 1'b1;
                  if (!queued[ci] && queue_len < NUM_CONSUMERS) begin
                     slots[tail] = ci;
                     tail        = tail + 1'b1;
                     queue_len   = queue_len + 1;
                     queued[ci]  = 1'b1;
                  end
                  if (sleepers < COUNT_MAX) sleepers = sleepers + 1;
               end
            end
            OP_STEAL_REQ: begin
               if (stealers * 2 < int'(active) && stealers < COUNT_MAX) begin
                  stealers        = stealers + 1;
                  r.steal_granted = 1'b1;
               end
            end
            OP_STEAL_END: begin
               r.was_last_stealer = (stealers == 1);
               if (stealers > 0) stealers = stealers - 1;
            end
            OP_STOP: begin
               halted = 1'b1;
               while (n_woken < NUM_CONSUMERS && wake_oldest(c)) begin
                  woken[n_woken] = c;
                  n_woken        = n_woken + 1;
               end
               while (queue_len > 0) void'(pop_oldest());
            end
            default: ;
         endcase
         r.stopped_flag = halted;
         if (n_woken == 0) begin
            add_expected(r);
         end else begin
            for (int k = 0; k < n_woken; k++) begin
               r             = '0;
               r.woken_valid = 1'b1;
               r.woken_index = woken[k];
               r.stopped_flag = 1'b1;
               r.last_result = (k == n_woken - 1);
               add_expected(r);
            end
         end
      endfunction

      task report(string msg);
         if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches = mismatches + 1;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pend_count == 0) begin
            report($sformatf("result %p arrived with none outstanding", got));
            return;
         end
         want = take_expected();
         if (got.woken_valid !== want.woken_valid)
            report($sformatf("woken_valid %b, wanted %b", got.woken_valid, want.woken_valid));
         if (got.woken_index !== want.woken_index)
            report($sformatf("woken_index %0d, wanted %0d", got.woken_index, want.woken_index));
         if (got.steal_granted !== want.steal_granted)
            report($sformatf("steal_granted %b, wanted %b",
                             got.steal_granted, want.steal_granted));
         if (got.was_last_stealer !== want.was_last_stealer)
            report($sformatf("was_last_stealer %b, wanted %b",
                             got.was_last_stealer, want.was_last_stealer));
         if (got.stopped_flag !== want.stopped_flag)
            report($sformatf("stopped_flag %b, wanted %b", got.stopped_flag, want.stopped_flag));
         if (got.last_result !== want.last_result)
            report($sformatf("last_result %b, wanted %b", got.last_result, want.last_result));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode;
   logic [CI_W-1:0]     req_consumer_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_woken_valid;
   logic [CI_W-1:0]     rsp_woken_index;
   logic                rsp_steal_granted;
   logic                rsp_was_last_stealer;
   logic                rsp_stopped_flag;
   logic                rsp_last_result;
   logic                csr_wr_en;
   logic [ACTIVE_W-1:0] csr_wr_data;

   bit idle_on   = 1'b1;
   bit long_hold = 1'b0;

   wake_steal_ledger ledger = new();

   sleeper_wake_and_steal_manager_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_consumer_index   (req_consumer_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_woken_valid      (rsp_woken_valid),
      .rsp_woken_index      (rsp_woken_index),
      .rsp_steal_granted    (rsp_steal_granted),
      .rsp_was_last_stealer (rsp_was_last_stealer),
      .rsp_stopped_flag     (rsp_stopped_flag),
      .rsp_last_result      (rsp_last_result),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_response('{rsp_woken_valid, rsp_woken_index, rsp_steal_granted,
                                 rsp_was_last_stealer, rsp_stopped_flag, rsp_last_result});
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_req(logic [OP_W-1:0] op, logic [CI_W-1:0] ci);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_consumer_index <= ci;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_request(op, ci);
      @(negedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [OP_W-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 20)      op = OP_NEW_TASK;
      else if (pick < 35) op = OP_WAKE;
      else if (pick < 68) op = OP_SLEEP;
      else if (pick < 76) op = OP_STEAL_REQ;
      else if (pick < 89) op = OP_STEAL_END;
      else if (pick < 95) op = OP_STOP;
      else                op = (pick < 97) ? OP_SPARE_LO : OP_SPARE_HI;
      send_req(op, CI_W'($urandom_range(0, NUM_CONSUMERS - 1)));
   endtask

   task automatic fill_and_stop();
      logic [CI_W-1:0] order[NUM_CONSUMERS];
      logic [CI_W-1:0] t;
      int j;
      foreach (order[i]) order[i] = CI_W'(i);
      for (int i = NUM_CONSUMERS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i]) send_req(OP_SLEEP, order[i]);
      send_req(OP_STOP, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.pend_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_active(logic [ACTIVE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ledger.active = value;
      @(negedge clock);
   endtask

   initial begin
      logic [ACTIVE_W-1:0] settings[6];
      settings           = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd7, 5'd2};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = OP_NEW_TASK;
      req_consumer_index = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_req(OP_NEW_TASK, 4'd0);
      send_req(OP_STEAL_END, 4'd15);
      send_req(OP_SLEEP, 4'd0);
      send_req(OP_SLEEP, 4'd15);
      send_req(OP_SLEEP, 4'd7);
      send_req(OP_WAKE, 4'd0);
      send_req(OP_WAKE, 4'd3);
      send_req(OP_SLEEP, 4'd15);
      send_req(OP_NEW_TASK, 4'd0);
      send_req(OP_WAKE, 4'd7);
      send_req(OP_SLEEP, 4'd7);
      send_req(OP_STEAL_REQ, 4'd0);
      send_req(OP_NEW_TASK, 4'd0);
      send_req(OP_STEAL_END, 4'd0);
      send_req(OP_STEAL_END, 4'd0);
      send_req(OP_SLEEP, 4'd9);
      send_req(OP_STOP, 4'd0);
      send_req(OP_STOP, 4'd15);
      send_req(OP_SPARE_LO, 4'd0);
      send_req(OP_SPARE_HI, 4'd15);
      settle();

      foreach (settings[p]) begin
         if (p == 5) idle_on = 1'b0;
         write_active(settings[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
         if (p == 2) begin
            long_hold = 1'b1;
            fill_and_stop();
            repeat (8) send_random();
         end
         settle();
      end

      if (ledger.pend_count != 0)
         ledger.report($sformatf("%0d results never arrived", ledger.pend_count));
      if (ledger.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
